// ===== rtl/serial_frame_receiver_xor_unit_defines.svh =====
// -----------------------------------------------------------------------------
// serial frame receiver assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// -----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_RECEIVER_XOR_UNIT_DEFINES_SVH
`define SERIAL_FRAME_RECEIVER_XOR_UNIT_DEFINES_SVH

// same-cycle implication
`define SFX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SFX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sfx_pkg.sv =====
// -----------------------------------------------------------------------------
// sfx_pkg
// types and codes shared by the serial frame receiver modules
// -----------------------------------------------------------------------------
package sfx_pkg;

  // result kinds
  typedef enum logic [2:0] {
    KIND_PAYLOAD = 3'd0,
    KIND_SYNC    = 3'd1,
    KIND_BADSUM  = 3'd2,
    KIND_BADLEN  = 3'd3,
    KIND_SHORT   = 3'd4
  } kind_e;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_START_BYTE = 1'b0,
    CFG_MAX_LENGTH = 1'b1
  } cfg_idx_e;

  // controller states
  typedef enum logic [2:0] {
    ST_HUNT  = 3'd0,
    ST_LEN   = 3'd1,
    ST_DATA  = 3'd2,
    ST_SUM   = 3'd3,
    ST_RD    = 3'd4,
    ST_LOAD  = 3'd5
  } state_e;

  localparam logic [7:0] StartByteReset = 8'd255;
  localparam logic [6:0] MaxLengthReset = 7'd50;
  localparam int unsigned PayloadOffset = 2;
  localparam int unsigned MinFrameLen   = 3;

  // controller to datapath
  typedef struct packed {
    logic  start_frame;
    logic  take_len;
    logic  take_data;
    logic  set_ping;
    logic  load_result;
    kind_e result_kind;
    logic  drain_init;
    logic  drain_read;
    logic  drain_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic byte_is_start;
    logic len_bad;
    logic len_zero;
    logic data_done;
    logic sum_ok;
    logic len_short;
    logic drain_last;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/sfx_ram.sv =====
// -----------------------------------------------------------------------------
// sfx_ram
// single write port, single read port ram with registered read data
// -----------------------------------------------------------------------------
module sfx_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sfx_ctrl.sv =====
// -----------------------------------------------------------------------------
// sfx_ctrl
// frame phase state machine, issues datapath commands
// -----------------------------------------------------------------------------
module sfx_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sfx_pkg::sts_t sts_i,
  output sfx_pkg::cmd_t cmd_o
);
  import sfx_pkg::*;

  state_e state_q, state_d;
  logic   in_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    in_fire    = 1'b0;
    unique case (state_q)
      ST_HUNT, ST_LEN, ST_DATA, ST_SUM: begin
        in_ready_o = sts_i.out_free;
        in_fire    = in_valid_i && sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase

    unique case (state_q)
      ST_HUNT: begin
        if (in_fire && sts_i.byte_is_start) begin
          cmd_o.start_frame = 1'b1;
          state_d           = ST_LEN;
        end
      end
      ST_LEN: begin
        if (in_fire) begin
          priority if (sts_i.len_bad) begin
            cmd_o.load_result = 1'b1;
            cmd_o.result_kind = KIND_BADLEN;
            state_d           = ST_HUNT;
          end else if (sts_i.len_zero) begin
            cmd_o.set_ping    = 1'b1;
            cmd_o.load_result = 1'b1;
            cmd_o.result_kind = KIND_SYNC;
            state_d           = ST_HUNT;
          end else begin
            cmd_o.take_len = 1'b1;
            state_d        = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (in_fire) begin
          cmd_o.take_data = 1'b1;
          if (sts_i.data_done) begin
            state_d = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        if (in_fire) begin
          priority if (!sts_i.sum_ok) begin
            cmd_o.load_result = 1'b1;
            cmd_o.result_kind = KIND_BADSUM;
            state_d           = ST_HUNT;
          end else if (sts_i.len_short) begin
            cmd_o.load_result = 1'b1;
            cmd_o.result_kind = KIND_SHORT;
            state_d           = ST_HUNT;
          end else begin
            cmd_o.drain_init = 1'b1;
            state_d          = ST_RD;
          end
        end
      end
      ST_RD: begin
        cmd_o.drain_read = 1'b1;
        state_d          = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.drain_load = 1'b1;
          state_d          = sts_i.drain_last ? ST_HUNT : ST_RD;
        end
      end
      default: begin
        state_d = ST_HUNT;
      end
    endcase
  end

endmodule

// ===== rtl/sfx_dp.sv =====
// -----------------------------------------------------------------------------
// sfx_dp
// config registers, counters, checksum, frame store and output register
// -----------------------------------------------------------------------------
module sfx_dp #(
  parameter int unsigned FrameDepth = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [0:0]    cfg_idx_i,
  input  logic [7:0]    cfg_data_i,
  input  logic [7:0]    rx_byte_i,
  input  sfx_pkg::cmd_t cmd_i,
  output sfx_pkg::sts_t sts_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [2:0]    kind_o,
  output logic [7:0]    data_byte_o,
  output logic [7:0]    route_byte_o,
  output logic [7:0]    function_byte_o,
  output logic          last_o,
  output logic          send_ack_o
);
  import sfx_pkg::*;

  localparam int unsigned LenW  = $clog2(FrameDepth + 1);
  localparam int unsigned AddrW = $clog2(FrameDepth);

  logic [7:0]      start_byte_q;
  logic [6:0]      max_length_q;
  logic [LenW-1:0] frame_length_q;
  logic [LenW-1:0] bytes_taken_q;
  logic [LenW-1:0] rd_idx_q;
  logic [7:0]      running_xor_q;
  logic [7:0]      route_q;
  logic [7:0]      func_q;
  logic            ping_seen_q;
  logic [7:0]      ram_rdata;

  logic            out_valid_q;
  kind_e           kind_q;
  logic [7:0]      data_q;
  logic [7:0]      route_out_q;
  logic [7:0]      func_out_q;
  logic            last_q;
  logic            ack_q;

  logic [LenW:0]   taken_inc;
  logic [LenW:0]   rd_inc;

  assign taken_inc = (LenW+1)'(bytes_taken_q) + (LenW+1)'(1);
  assign rd_inc    = (LenW+1)'(rd_idx_q) + (LenW+1)'(1);

  // status toward the controller
  assign sts_o.byte_is_start = (rx_byte_i == start_byte_q);
  assign sts_o.len_bad       = (rx_byte_i > {1'b0, max_length_q}) ||
                               ({1'b0, rx_byte_i} > 9'(FrameDepth));
  assign sts_o.len_zero      = (rx_byte_i == 8'd0);
  assign sts_o.data_done     = (taken_inc >= (LenW+1)'(frame_length_q));
  assign sts_o.sum_ok        = (running_xor_q == rx_byte_i);
  assign sts_o.len_short     = (frame_length_q < LenW'(MinFrameLen));
  assign sts_o.drain_last    = (rd_inc == (LenW+1)'(frame_length_q));
  assign sts_o.out_free      = !out_valid_q || out_ready_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= StartByteReset;
      max_length_q <= MaxLengthReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_START_BYTE: start_byte_q <= cfg_data_i;
        CFG_MAX_LENGTH: max_length_q <= cfg_data_i[6:0];
        default:        start_byte_q <= start_byte_q;
      endcase
    end
  end

  // frame tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_length_q <= '0;
      bytes_taken_q  <= '0;
      rd_idx_q       <= '0;
      running_xor_q  <= '0;
      ping_seen_q    <= 1'b0;
    end else begin
      if (cmd_i.start_frame) begin
        running_xor_q <= rx_byte_i;
      end
      if (cmd_i.take_len) begin
        frame_length_q <= LenW'(rx_byte_i);
        bytes_taken_q  <= '0;
        running_xor_q  <= running_xor_q ^ rx_byte_i;
      end
      if (cmd_i.take_data) begin
        bytes_taken_q <= taken_inc[LenW-1:0];
        running_xor_q <= running_xor_q ^ rx_byte_i;
      end
      if (cmd_i.set_ping) begin
        ping_seen_q <= 1'b1;
      end
      if (cmd_i.drain_init) begin
        rd_idx_q <= LenW'(PayloadOffset);
      end else if (cmd_i.drain_load) begin
        rd_idx_q <= rd_inc[LenW-1:0];
      end
    end
  end

  // header bytes kept aside so the store needs one read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_data && bytes_taken_q == LenW'(0)) begin
      route_q <= rx_byte_i;
    end
    if (cmd_i.take_data && bytes_taken_q == LenW'(1)) begin
      func_q <= rx_byte_i;
    end
  end

  sfx_ram #(
    .Width (8),
    .Depth (FrameDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.take_data),
    .waddr_i (bytes_taken_q[AddrW-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (cmd_i.drain_read),
    .raddr_i (rd_idx_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_result || cmd_i.drain_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      kind_q      <= cmd_i.result_kind;
      data_q      <= '0;
      route_out_q <= '0;
      func_out_q  <= '0;
      last_q      <= 1'b1;
      ack_q       <= (cmd_i.result_kind == KIND_SYNC) ||
                     ((cmd_i.result_kind == KIND_SHORT) && ping_seen_q);
    end else if (cmd_i.drain_load) begin
      kind_q      <= KIND_PAYLOAD;
      data_q      <= ram_rdata;
      route_out_q <= route_q;
      func_out_q  <= func_q;
      last_q      <= sts_o.drain_last;
      ack_q       <= sts_o.drain_last && ping_seen_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign data_byte_o     = data_q;
  assign route_byte_o    = route_out_q;
  assign function_byte_o = func_out_q;
  assign last_o          = last_q;
  assign send_ack_o      = ack_q;

endmodule

// ===== rtl/serial_frame_receiver_xor_unit.sv =====
// -----------------------------------------------------------------------------
// serial_frame_receiver_xor_unit
// start/length framed byte receiver with xor checksum and payload readout
// -----------------------------------------------------------------------------
//  channel   | handshake                 | payload
//  ----------+---------------------------+--------------------------------------
//  input     | in_valid_i / in_ready_o   | rx_byte_i
//  result    | out_valid_o / out_ready_i | kind_o data_byte_o route_byte_o
//            |                           | function_byte_o last_o send_ack_o
//  config    | cfg_we_i (no wait)        | cfg_idx_i cfg_data_i
//
//  one input beat per cycle while the result register is free or being taken
//  a good checksum of an n-byte frame (n of at least three) drains n-2 payload beats,
//  each paced by the registered read port of the frame store; no input taken meanwhile
//  reset is asynchronous and needs no clearing pass: store entries are read
//  only after being written in the same frame
//  a stalled result register holds off inputs; config writes land at once
// -----------------------------------------------------------------------------
`include "serial_frame_receiver_xor_unit_defines.svh"

module serial_frame_receiver_xor_unit #(
  parameter int unsigned FRAME_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration writes
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  // received bytes
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  // results
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] kind_o,
  output logic [7:0] data_byte_o,
  output logic [7:0] route_byte_o,
  output logic [7:0] function_byte_o,
  output logic       last_o,
  output logic       send_ack_o
);
  import sfx_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // phase sequencing
  sfx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // checksum, counters, frame store and result register
  sfx_dp #(
    .FrameDepth (FRAME_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .rx_byte_i       (rx_byte_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .data_byte_o     (data_byte_o),
    .route_byte_o    (route_byte_o),
    .function_byte_o (function_byte_o),
    .last_o          (last_o),
    .send_ack_o      (send_ack_o)
  );

  // a payload beat never overwrites a result still waiting
  `SFX_ASSERT_NOW(a_drain_no_overwrite, cmd.drain_load, sts.out_free, "payload overwrote result")

  // no input beat is taken while the store is being read out
  `SFX_ASSERT_NOW(a_no_input_in_drain, in_ready_o, !(cmd.drain_read || cmd.drain_load), "input during drain")

  // single results come only from an accepted beat
  `SFX_ASSERT_NOW(a_result_from_beat, cmd.load_result, in_valid_i && in_ready_o, "result without beat")

  // acknowledge request only ever rides on a last beat
  `SFX_ASSERT_NOW(a_ack_on_last, out_valid_o && send_ack_o, last_o, "ack on non-last beat")

endmodule
